// ----- sv/assert_macros.svh -----
// Assertion macros shared by the job picker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DJP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("djp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DJP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("djp: next-cycle check failed");

`endif

// ----- sv/djp_pkg.sv -----
// Types and constants of the dependency-aware job picker.
package djp_pkg;

  localparam int MODE_W   = 3;
  localparam int THREAD_W = 3;
  localparam int JOB_W    = 4;
  localparam int SLOT_W   = 4;
  localparam int MASK_W   = 16;
  localparam int LEN_W    = 5;
  localparam int JIU_W    = 5;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;

  localparam logic [MODE_W-1:0] MODE_LOAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SLOT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DONE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REQ  = 3'd4;

  localparam logic [JIU_W-1:0] JIU_RESET = 5'd16;
  localparam logic             REG_JIU   = 1'b0;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [THREAD_W-1:0] thread;
    logic [JOB_W-1:0]    job;
    logic [SLOT_W-1:0]   slot;
    logic [MASK_W-1:0]   prereq_mask;
    logic [LEN_W-1:0]    list_length;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [JOB_W-1:0] next_job;
    logic             has_pending;
  } out_t;

endpackage

// ----- sv/dependency_aware_job_picker_unit.sv -----
// Top level of the dependency-aware job picker: control, walk pipeline, registers.
//
//  channel  ports                                  direction  beat taken when
//  -------  -------------------------------------  ---------  -------------------------
//  input    start, busy, in_data                   in         start && !busy
//  result   out_valid, out_data                    out        every out_valid cycle
//  config   psel penable pwrite paddr pwdata ...   in/out     psel&&penable&&pwrite
//
// Load, slot write, length and mark-done items never raise busy; their result beat
//   shows in the next cycle.
// A request holds busy until its walk has drained: the walk reads one list entry
//   per cycle from the list memory, then that job's mask from the mask memory; the
//   mask check is the third stage.
// Reset (rst_n low, synchronous) clears done bits, list lengths, mask valid bits and
//   jobs_in_use (to 16); no clearing pass is needed. List slots stay undefined.
// The receiver cannot stall: each result is strobed on out_valid for exactly one cycle.
`include "assert_macros.svh"

module dependency_aware_job_picker_unit #(
  parameter int MAX_JOBS    = 16,
  parameter int MAX_THREADS = 8,
  parameter int MAX_LIST    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  input  djp_pkg::in_t                in_data,
  output logic                        busy,
  // result channel
  output logic                        out_valid,
  output djp_pkg::out_t               out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [djp_pkg::PADDR_W-1:0] paddr,
  input  logic [djp_pkg::CFG_W-1:0]   pwdata,
  output logic [djp_pkg::CFG_W-1:0]   prdata,
  output logic                        pready
);

  localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int SW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int LW = $clog2(MAX_LIST + 1);
  localparam int MW = djp_pkg::MASK_W;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [djp_pkg::JIU_W-1:0] jiu_r;
  logic [MAX_JOBS-1:0]       done_r;
  logic [LW-1:0]             len_arr_r [MAX_THREADS];

  logic                      busy_r;
  logic [TW-1:0]             thr_r;
  logic [LW-1:0]             len_r;
  logic [LW-1:0]             idx_r;
  logic [MW-1:0]             cm_r;
  logic                      s1_v_r;
  logic                      s2_v_r;
  logic [djp_pkg::JOB_W-1:0] s2_job_r;
  logic                      s2_jok_r;
  logic                      found_r;
  logic [djp_pkg::JOB_W-1:0] next_r;
  logic                      pend_r;
  logic                      out_valid_r;
  djp_pkg::out_t             out_r;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic          accept;
  logic          thr_ok;
  logic          job_ok;
  logic          slot_ok;
  logic [LW-1:0] len_sat;
  logic          is_load, is_slot, is_len, is_done, is_req;

  assign accept  = start && !busy_r;
  assign thr_ok  = int'(in_data.thread) < MAX_THREADS;
  assign job_ok  = int'(in_data.job) < MAX_JOBS;
  assign slot_ok = int'(in_data.slot) < MAX_LIST;
  assign len_sat = LW'((int'(in_data.list_length) > MAX_LIST) ? MAX_LIST
                                                              : int'(in_data.list_length));

  always_comb begin
    is_load = 1'b0;
    is_slot = 1'b0;
    is_len  = 1'b0;
    is_done = 1'b0;
    is_req  = 1'b0;
    unique case (in_data.mode)
      djp_pkg::MODE_LOAD: is_load = 1'b1;
      djp_pkg::MODE_SLOT: is_slot = 1'b1;
      djp_pkg::MODE_LEN:  is_len  = 1'b1;
      djp_pkg::MODE_DONE: is_done = 1'b1;
      djp_pkg::MODE_REQ:  is_req  = 1'b1;
      default: ;
    endcase
  end

  // Check mask: low min(jobs_in_use, MAX_JOBS) prerequisite bits.
  logic [MW-1:0] cm_nxt;
  int            cm_n;
  always_comb begin
    cm_n = (int'(jiu_r) > MAX_JOBS) ? MAX_JOBS : int'(jiu_r);
    for (int k = 0; k < MW; k++) begin
      cm_nxt[k] = (k < cm_n);
    end
  end

  // ---------------------------------------------------------------------------
  // Walk pipeline: stage 0 reads the list, stage 1 reads the mask,
  // stage 2 checks the job.
  // ---------------------------------------------------------------------------
  logic                      issue;
  logic                      finish;
  logic [djp_pkg::JOB_W-1:0] list_rdata;
  logic                      list_jok;
  logic [JW-1:0]             mask_raddr;
  logic [MW-1:0]             mask_rdata;
  logic [MW-1:0]             done_w;
  logic                      live;
  logic                      blocked;

  assign issue    = busy_r && (idx_r < len_r);
  assign finish   = busy_r && !issue && !s1_v_r && !s2_v_r;
  assign list_jok = int'(list_rdata) < MAX_JOBS;

  // read the mask of the job just read from the list; entry 0 when out of range
  assign mask_raddr = list_jok ? JW'(list_rdata) : '0;

  // done bits seen at the mask width; bits past MAX_JOBS are masked off anyway
  always_comb begin
    done_w = '0;
    for (int k = 0; k < MW; k++) begin
      if (k < MAX_JOBS) begin
        done_w[k] = done_r[k];
      end
    end
  end

  assign live    = s2_jok_r && !done_r[JW'(s2_job_r)];
  assign blocked = |(mask_rdata & cm_r & ~done_w);

  djp_list_mem #(
    .MAX_THREADS (MAX_THREADS),
    .MAX_LIST    (MAX_LIST)
  ) u_list_mem (
    .clk   (clk),
    .we    (accept && is_slot && thr_ok && slot_ok),
    .wthr  (TW'(in_data.thread)),
    .wslot (SW'(in_data.slot)),
    .wdata (in_data.job),
    .rthr  (thr_r),
    .rslot (idx_r[SW-1:0]),
    .rdata (list_rdata)
  );

  djp_mask_mem #(
    .MAX_JOBS (MAX_JOBS)
  ) u_mask_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (accept && is_load && job_ok),
    .waddr (JW'(in_data.job)),
    .wdata (in_data.prereq_mask),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jiu_r       <= djp_pkg::JIU_RESET;
      done_r      <= '0;
      busy_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      len_r       <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      next_r      <= '0;
      for (int t = 0; t < MAX_THREADS; t++) begin
        len_arr_r[t] <= '0;
      end
    end else begin
      // every other item answers all zero in the next cycle; a request
      // answers once its walk has drained
      out_valid_r <= (accept && !is_req) || finish;

      if (psel && penable && pwrite && (paddr[2] == djp_pkg::REG_JIU)) begin
        jiu_r <= pwdata[djp_pkg::JIU_W-1:0];
      end

      if (accept) begin
        if (is_len && thr_ok) begin
          len_arr_r[TW'(in_data.thread)] <= len_sat;
        end
        if (is_done && job_ok) begin
          done_r[JW'(in_data.job)] <= 1'b1;
        end
        if (is_req) begin
          busy_r  <= 1'b1;
          idx_r   <= '0;
          len_r   <= thr_ok ? len_arr_r[TW'(in_data.thread)] : '0;
          found_r <= 1'b0;
          pend_r  <= 1'b0;
          next_r  <= '0;
        end
      end

      if (issue) begin
        idx_r <= idx_r + LW'(1);
      end
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;

      if (s2_v_r && live) begin
        pend_r <= 1'b1;
        if (!found_r && !blocked) begin
          found_r <= 1'b1;
          next_r  <= s2_job_r;
        end
      end

      if (finish) begin
        busy_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && is_req) begin
      thr_r <= thr_ok ? TW'(in_data.thread) : '0;
      cm_r  <= cm_nxt;
    end
    s2_job_r <= list_rdata;
    s2_jok_r <= list_jok;
    if (accept && !is_req) begin
      out_r <= '0;
    end else if (finish) begin
      out_r.found       <= found_r;
      out_r.next_job    <= next_r;
      out_r.has_pending <= pend_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == djp_pkg::REG_JIU)
                     ? {{(djp_pkg::CFG_W - djp_pkg::JIU_W){1'b0}}, jiu_r}
                     : '0;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DJP_ASSERT_SAME(a_no_beat_while_busy, out_valid_r, !busy_r)
  `DJP_ASSERT_SAME(a_pipe_inside_walk, s1_v_r || s2_v_r, busy_r)
  `DJP_ASSERT_SAME(a_idx_in_bounds, busy_r, idx_r <= len_r)
  `DJP_ASSERT_SAME(a_found_is_pending, out_valid_r && out_r.found, out_r.has_pending)
  `DJP_ASSERT_NEXT(a_short_item_beat, accept && !is_req, out_valid_r)

endmodule

// ----- sv/djp_list_mem.sv -----
// Per-thread job list memory, one write and one registered read port.
module djp_list_mem #(
  parameter int  MAX_THREADS = 8,
  parameter int  MAX_LIST    = 16,
  localparam int TW          = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1,
  localparam int SW          = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [TW-1:0]              wthr,
  input  logic [SW-1:0]              wslot,
  input  logic [djp_pkg::JOB_W-1:0]  wdata,
  input  logic [TW-1:0]              rthr,
  input  logic [SW-1:0]              rslot,
  output logic [djp_pkg::JOB_W-1:0]  rdata
);

  logic [djp_pkg::JOB_W-1:0] mem [MAX_THREADS][MAX_LIST];
  logic [djp_pkg::JOB_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wthr][wslot] <= wdata;
    end
    rdata_r <= mem[rthr][rslot];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/djp_mask_mem.sv -----
// Prerequisite mask memory; per-entry valid bits give the all-zero reset.
module djp_mask_mem #(
  parameter int  MAX_JOBS = 16,
  localparam int JW       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [JW-1:0]              waddr,
  input  logic [djp_pkg::MASK_W-1:0] wdata,
  input  logic [JW-1:0]              raddr,
  output logic [djp_pkg::MASK_W-1:0] rdata
);

  logic [djp_pkg::MASK_W-1:0] mem [MAX_JOBS];
  logic [MAX_JOBS-1:0]        vld_r;
  logic [djp_pkg::MASK_W-1:0] rdata_r;
  logic                       rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  // unwritten entry reads as zero
  assign rdata = rvld_r ? rdata_r : '0;

endmodule

// ----- bench/job_pick_sb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard class: predicts job picker results and checks them in order.
package job_pick_sb_pkg;
  import djp_pkg::*;

  localparam int NUM_JOBS    = 16;
  localparam int NUM_THREADS = 8;
  localparam int LIST_DEPTH  = 16;

  class pick_tracker;
    logic [NUM_JOBS-1:0] done_bits;
    logic [MASK_W-1:0]   masks [NUM_JOBS];
    logic [JOB_W-1:0]    lists [NUM_THREADS][LIST_DEPTH];
    logic [LEN_W-1:0]    lens [NUM_THREADS];
    logic [JIU_W-1:0]    jobs_in_use;
    out_t                expected_picks [$];
    int                  failures;
    int                  requests;
    int                  hits;

    function new();
      done_bits = '0;
      foreach (masks[j]) masks[j] = '0;
      foreach (lists[t, s]) lists[t][s] = '0;
      foreach (lens[t]) lens[t] = '0;
      jobs_in_use = JIU_RESET;
      failures = 0;
      requests = 0;
      hits = 0;
    endfunction

    function void set_jobs_in_use(logic [CFG_W-1:0] value);
      jobs_in_use = value[JIU_W-1:0];
    endfunction

    // Apply one accepted beat to the shadow state and queue its result.
    function void note_item(in_t it);
      out_t                pick;
      logic [NUM_JOBS:0]   span;
      logic [NUM_JOBS-1:0] checked;
      int                  i;
      int                  j;
      pick = '0;
      span = (NUM_JOBS + 1)'(1) << ((jobs_in_use > NUM_JOBS) ? NUM_JOBS : jobs_in_use);
      checked = NUM_JOBS'(span - (NUM_JOBS + 1)'(1));
      case (it.mode)
        MODE_LOAD: masks[it.job] = it.prereq_mask;
        MODE_SLOT: lists[it.thread][it.slot] = it.job;
        MODE_LEN:  lens[it.thread] = (it.list_length > LIST_DEPTH) ?
                                     LEN_W'(LIST_DEPTH) : it.list_length;
        MODE_DONE: done_bits[it.job] = 1'b1;
        MODE_REQ: begin
          requests++;
          for (i = 0; i < lens[it.thread]; i++) begin
            j = int'(lists[it.thread][i]);
            if (!done_bits[j]) begin
              pick.has_pending = 1'b1;
              if (!pick.found && (masks[j] & checked & ~done_bits) == '0) begin
                pick.found = 1'b1;
                pick.next_job = JOB_W'(j);
              end
            end
          end
          if (pick.found) hits++;
        end
        default: ;
      endcase
      expected_picks.push_back(pick);
    endfunction

    function void check_pick(out_t got);
      out_t want;
      if (expected_picks.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        failures++;
      end else begin
        want = expected_picks.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          failures++;
        end
        if (got.next_job !== want.next_job) begin
          $error("next_job: expected %0d, got %0d", want.next_job, got.next_job);
          failures++;
        end
        if (got.has_pending !== want.has_pending) begin
          $error("has_pending: expected %0d, got %0d", want.has_pending,
                 got.has_pending);
          failures++;
        end
      end
    endfunction
  endclass

endpackage

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the job picker regression: stimulus, register access, result checks.
module testbench;
  import djp_pkg::*;
  import job_pick_sb_pkg::*;

  // Opcodes above request: block must ignore them and answer all zero.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam int MAX_GAP       = 17;
  localparam int PHASE_ITEMS   = 76;
  localparam int SETTLE_CYCLES = 25;    // outlasts the longest request: 16 entries, 3 stages
  localparam int STALL_LIMIT   = 2000;  // quiet cycles before we give up
  localparam logic [PADDR_W-1:0] JIU_ADDR = PADDR_W'(4 * REG_JIU);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  in_t                in_data = '0;
  logic               busy;
  logic               out_valid;
  out_t               out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0]   pwdata = '0;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  pick_tracker picks = new();

  // Which list slots hold a real job; a request must never walk past these.
  logic [LIST_DEPTH-1:0] slot_written [NUM_THREADS];
  int                    items_sent = 0;
  logic                  burst = 1'b0;

  dependency_aware_job_picker_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side never stalls: every strobed cycle is a beat.
  always @(posedge clk) begin
    if (rst_n && out_valid) picks.check_pick(out_data);
  end

  // Watchdog: any input or result beat resets the quiet count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((start && !busy) || out_valid)) quiet = 0;
      else quiet++;
    end
    $display("dependency_aware_job_picker_unit regression: fail");
    $finish;
  end

  // Gap draw: bursts run back to back, otherwise a random idle gap up to MAX_GAP.
  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Present one beat after an optional idle gap and hold it until taken.
  // start stays high on return so a zero-gap follow-up is back to back.
  task automatic send_item(input in_t it, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    picks.note_item(it);
    if (it.mode == MODE_SLOT) slot_written[it.thread][it.slot] = 1'b1;
    items_sent++;
  endtask

  // Sender holds off until every queued result has shown up.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (picks.expected_picks.size() != 0);
  endtask

  // Register access with a setup and an enable phase; a read is checked against the shadow value.
  task automatic cfg_access(input logic wr, input logic [CFG_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= JIU_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      picks.set_jobs_in_use(data);
    end else if (prdata !== CFG_W'(picks.jobs_in_use)) begin
      $error("jobs_in_use: expected %0d, got %0d", picks.jobs_in_use, prdata);
      picks.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t make_item(logic [MODE_W-1:0] mode, int thread, int job,
                                    int slot, logic [MASK_W-1:0] mask, int len);
    in_t it;
    it.mode        = mode;
    it.thread      = THREAD_W'(thread);
    it.job         = JOB_W'(job);
    it.slot        = SLOT_W'(slot);
    it.prereq_mask = mask;
    it.list_length = LEN_W'(len);
    return it;
  endfunction

  // Longest run of written slots from the head of a thread's list.
  function automatic int written_prefix(int thread);
    int n;
    n = 0;
    while (n < LIST_DEPTH && slot_written[thread][n]) n++;
    return n;
  endfunction

  // Random beat: all fields random, then the opcode and the field it uses
  // are shaped. Lengths never reach past written slots; masks lean sparse
  // so requests find work often enough.
  function automatic in_t rand_item();
    in_t it;
    int  kind;
    int  prefix;
    it.thread      = THREAD_W'($urandom);
    it.job         = JOB_W'($urandom);
    it.slot        = SLOT_W'($urandom);
    it.prereq_mask = MASK_W'($urandom);
    it.list_length = LEN_W'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      it.mode = MODE_LOAD;
      case ($urandom_range(0, 3))
        0: it.prereq_mask = '0;
        1: it.prereq_mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        2: it.prereq_mask = MASK_W'($urandom & $urandom & $urandom);
        default: ;
      endcase
    end else if (kind < 30) begin
      it.mode = MODE_SLOT;
    end else if (kind < 42) begin
      it.mode = MODE_LEN;
      prefix = written_prefix(int'(it.thread));
      it.list_length = (prefix == LIST_DEPTH) ? LEN_W'($urandom) :
                       LEN_W'($urandom_range(0, prefix));
    end else if (kind < 44) begin
      it.mode = MODE_DONE;
    end else if (kind < 93) begin
      it.mode = MODE_REQ;
    end else begin
      it.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    end
    return it;
  endfunction

  // Well-formed list build: fill slots in order, set the length, then ask.
  // A full list takes a length of at least the depth, which saturates when above it.
  task automatic fill_thread(input int thread, input int n);
    in_t it;
    int  len;
    int  s;
    for (s = 0; s < n; s++) begin
      it = rand_item();
      it.mode = MODE_SLOT;
      it.thread = THREAD_W'(thread);
      it.slot = SLOT_W'(s);
      send_item(it, pick_gap());
    end
    len = (n == LIST_DEPTH) ? $urandom_range(LIST_DEPTH, 31) : n;
    send_item(make_item(MODE_LEN, thread, $urandom, $urandom, MASK_W'($urandom), len),
              pick_gap());
    repeat ($urandom_range(1, 3)) begin
      it = rand_item();
      it.mode = MODE_REQ;
      it.thread = THREAD_W'(thread);
      send_item(it, pick_gap());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings [5];
    in_t              it;
    int               p;
    int               n;
    int               leftover;

    foreach (slot_written[t]) slot_written[t] = '0;
    settings[0] = 32'd0;                      // no prerequisite checked
    settings[1] = 32'd1;
    settings[2] = 32'd31;                     // past the job count
    settings[3] = CFG_W'($urandom_range(2, 15));
    settings[4] = 32'd16;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, jobs_in_use at its reset value ----
    cfg_access(1'b0, '0);
    // empty list after reset, then an unused opcode with every bit set
    send_item(make_item(MODE_REQ, 0, 0, 0, '0, 0), 0);
    send_item(make_item(MODE_SPARE_HI, 7, 15, 15, '1, 31), pick_gap());
    // job 15 waits on every job, itself included, job 1 on job 0, job 2 on job 15
    send_item(make_item(MODE_LOAD, 0, 15, 0, 16'hFFFF, 31), pick_gap());
    send_item(make_item(MODE_LOAD, 0, 1, 0, 16'h0001, 0), pick_gap());
    send_item(make_item(MODE_LOAD, 0, 2, 0, 16'h8000, 0), pick_gap());
    // last slot of thread 0 written but never walked (its length stays 0)
    send_item(make_item(MODE_SLOT, 0, 15, 15, '0, 0), pick_gap());
    // thread 7 list: 15, 1, 0, 2
    send_item(make_item(MODE_SLOT, 7, 15, 0, '0, 0), pick_gap());
    send_item(make_item(MODE_SLOT, 7, 1, 1, '0, 0), pick_gap());
    send_item(make_item(MODE_SLOT, 7, 0, 2, '0, 0), pick_gap());
    send_item(make_item(MODE_SLOT, 7, 2, 3, '0, 0), pick_gap());
    send_item(make_item(MODE_LEN, 7, 0, 0, '0, 4), pick_gap());
    send_item(make_item(MODE_REQ, 7, 0, 0, '0, 0), pick_gap());      // picks job 0
    send_item(make_item(MODE_DONE, 0, 0, 0, '0, 0), pick_gap());
    send_item(make_item(MODE_REQ, 7, 0, 0, '0, 0), pick_gap());      // job 1 now free
    send_item(make_item(MODE_DONE, 0, 1, 0, '0, 0), pick_gap());
    send_item(make_item(MODE_REQ, 7, 0, 0, '0, 0), pick_gap());      // all blocked
    send_item(make_item(MODE_LOAD, 0, 15, 0, '0, 0), pick_gap());
    send_item(make_item(MODE_REQ, 7, 0, 0, '0, 0), pick_gap());      // job 15 free
    send_item(make_item(MODE_DONE, 0, 15, 0, '0, 0), pick_gap());
    send_item(make_item(MODE_REQ, 7, 0, 0, '0, 0), pick_gap());      // done job skipped

    // ---- random part, one phase per jobs_in_use setting ----
    foreach (settings[ph]) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_access(1'b1, settings[ph]);
      cfg_access(1'b0, '0);
      // first phase always builds one full list to reach length saturation
      if (ph == 0) fill_thread($urandom_range(0, NUM_THREADS - 1), LIST_DEPTH);
      p = 0;
      while (p < PHASE_ITEMS) begin
        if ($urandom_range(0, 49) == 0) begin
          drain();                            // sender backs off completely
        end
        if ($urandom_range(0, 24) == 0) begin
          n = $urandom_range(1, LIST_DEPTH);
          fill_thread($urandom_range(0, NUM_THREADS - 1), n);
          p += n + 2;
        end else begin
          it = rand_item();
          send_item(it, pick_gap());
          p++;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    leftover = picks.expected_picks.size();
    if (leftover != 0) $error("%0d expected results never arrived", leftover);

    $display("run covered %0d beats, %0d requests (%0d picked a job)",
             items_sent, picks.requests, picks.hits);
    $display("jobs_in_use went through 16, 0, 1, 31, %0d and 16", settings[3]);
    if (picks.failures == 0 && leftover == 0) begin
      $display("dependency_aware_job_picker_unit regression: pass");
    end else begin
      $display("dependency_aware_job_picker_unit regression: fail");
    end
    $finish;
  end

endmodule
